FILE: rtl/core/tandem_junction_counter_macros.svh
// Assertion macros used by the tandem junction counter top level.
`ifndef TANDEM_JUNCTION_COUNTER_MACROS_SVH
`define TANDEM_JUNCTION_COUNTER_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define TJC_ASSERT_IMP(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("tjc assertion failed");

// Checks that a condition implies a consequence in the next cycle.
`define TJC_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("tjc assertion failed");

`endif

FILE: rtl/core/tjc_pkg.sv
// Types and constants for the tandem junction counter.
package tjc_pkg;

    localparam int unsigned POS_W   = 32;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned CHROM_W = 8;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned IDX_OUT_W = 12;
    localparam int unsigned TABLE_ENTRIES = 4096;
    localparam logic [LEN_W-1:0] MIN_LEN_RESET = 16'd5;

    localparam logic [63:0] MIX_C1 = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_C2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] MIX_C3 = 64'hBF58476D1CE4E5B9;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIX0,
        ST_MIX1,
        ST_MIX2,
        ST_MIX3,
        ST_MIX4,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_UPDATE,
        ST_OUT
    } tjc_state_t;

endpackage

FILE: rtl/core/tjc_mul64.sv
// 64x64 multiplier (low 64 bits) built from 32-bit partial products over cycles.
module tjc_mul64
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] product
);
    logic [1:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic [63:0] a_reg, b_reg;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] op_a, op_b;
    logic [63:0] pp;
    logic        done_reg;

    // Step 0: lo*lo, step 1: hi(a)*lo(b), step 2: lo(a)*hi(b).
    always_comb
    begin
        unique case (step_reg)
            2'd0:
            begin
                op_a = a_reg[31:0];
                op_b = b_reg[31:0];
            end
            2'd1:
            begin
                op_a = a_reg[63:32];
                op_b = b_reg[31:0];
            end
            default:
            begin
                op_a = a_reg[31:0];
                op_b = b_reg[63:32];
            end
        endcase
        pp = {32'd0, op_a} * {32'd0, op_b};
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        acc_next  = acc_reg;
        if (busy_reg)
        begin
            if (step_reg == 2'd0)
            begin
                acc_next = pp;
            end
            else
            begin
                acc_next = acc_reg + {pp[31:0], 32'd0};
            end
            if (step_reg == 2'd2)
            begin
                busy_next = 1'b0;
                step_next = 2'd0;
            end
            else
            begin
                step_next = step_reg + 2'd1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            step_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 2'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= busy_reg && (step_reg == 2'd2);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (start && !busy_reg)
        begin
            a_reg <= a;
            b_reg <= b;
        end
    end

    assign product = acc_reg;
    assign done    = done_reg;
endmodule

FILE: rtl/core/tandem_junction_counter.sv
// Tandem junction counter top level: history, hash and table update.
//
//  channel | signals                                  | direction
//  in      | in_valid / in_ready, block fields        | into block
//  out     | out_valid / out_ready, junction fields   | out of block
//  cfg     | cfg_we / cfg_wdata (min_block_length)    | into block
//
// A block that forms no junction is taken while the block stays idle, back to back.
// A junction transaction runs three 64-bit multiplies for the hash, then one table
// read and check per probe through the synchronous-read table memory, with at most
// PROBE_LIMIT probes.
// After reset a clearing pass over all TABLE_ENTRIES (4096) entries zeroes the valid
// memory; in_ready stays low during it.
// A stalled result holds in the output register; a later junction waits for it.
module tandem_junction_counter
#(
    parameter int unsigned PROBE_LIMIT   = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  chrom_id,
    input  logic [31:0] read_start,
    input  logic [31:0] block_offset,
    input  logic [15:0] block_length,
    input  logic        strand,
    input  logic        last_block,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] junction_start1,
    output logic [31:0] junction_end1,
    output logic [31:0] junction_start2,
    output logic [31:0] junction_end2,
    output logic [7:0]  out_chrom,
    output logic        out_strand,
    output logic [11:0] entry_index,
    output logic [31:0] new_count,
    output logic        table_full
);
    import tjc_pkg::*;
    `include "tandem_junction_counter_macros.svh"

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam int unsigned PRB_W = $clog2(PROBE_LIMIT + 1);
    localparam int unsigned ENT_W = 64 + 64 + 8;

    tjc_state_t state_reg, state_next;

    logic [15:0] min_len_reg;
    logic [1:0]  hist_reg;
    logic [31:0] pstart_reg [2];
    logic [15:0] plen_reg [2];

    logic [63:0] ka_reg, kb_reg;
    logic [7:0]  chrom_reg;
    logic        strand_reg;
    logic [63:0] x_reg, x_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [PRB_W-1:0] probe_reg, probe_next;

    logic [ENT_W-1:0] key_mem [TABLE_ENTRIES];
    logic [63:0]      cnt_mem [TABLE_ENTRIES];
    logic             vld_mem [TABLE_ENTRIES];
    logic [ENT_W-1:0] key_rd;
    logic [63:0]      cnt_rd;
    logic             vld_rd;
    logic             clr_busy_reg;
    logic [IDX_W-1:0] clr_addr_reg;

    logic        mul_start;
    logic [63:0] mul_a, mul_b, mul_p;
    logic        mul_done;

    logic        out_valid_reg;
    logic        out_load;
    logic [11:0] res_idx_reg;
    logic [31:0] res_cnt_reg;
    logic        res_full_reg;
    logic [11:0] o_idx_next;
    logic [31:0] o_cnt_next;
    logic        o_full_next;
    logic        key_we, cnt_we;
    logic [63:0] cnt_wdata;
    logic [31:0] cur_start;
    logic        hit_cond;
    logic [31:0] old_cnt, inc_cnt;

    tjc_mul64 u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    assign cur_start = read_start + block_offset;
    assign in_ready  = (state_reg == ST_IDLE) && !clr_busy_reg;
    assign out_valid = out_valid_reg;
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);
    assign hit_cond  = key_rd == {ka_reg, kb_reg, chrom_reg};
    assign old_cnt   = strand_reg ? cnt_rd[63:32] : cnt_rd[31:0];
    assign inc_cnt   = (vld_rd && old_cnt != 32'hFFFF_FFFF) ? old_cnt + 32'd1
                     : (vld_rd ? old_cnt : 32'd1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready && hist_reg == 2'd2 &&
                    plen_reg[0] >= min_len_reg && plen_reg[1] >= min_len_reg &&
                    block_length >= min_len_reg)
                begin
                    state_next = ST_MIX0;
                end
            end
            ST_MIX0: state_next = ST_MIX1;
            ST_MIX1: if (mul_done) state_next = ST_MIX2;
            ST_MIX2: if (mul_done) state_next = ST_MIX3;
            ST_MIX3: if (mul_done) state_next = ST_MIX4;
            ST_MIX4: state_next = ST_PROBE_RD;
            ST_PROBE_RD: state_next = ST_PROBE_CHK;
            ST_PROBE_CHK:
            begin
                if (!vld_rd || hit_cond)
                begin
                    state_next = ST_UPDATE;
                end
                else if (probe_reg == PRB_W'(PROBE_LIMIT - 1))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_PROBE_RD;
                end
            end
            ST_UPDATE: state_next = ST_OUT;
            ST_OUT: if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath controls per state.
    always_comb
    begin
        mul_start   = 1'b0;
        mul_a       = x_reg;
        mul_b       = MIX_C1;
        x_next      = x_reg;
        slot_next   = slot_reg;
        probe_next  = probe_reg;
        key_we      = 1'b0;
        cnt_we      = 1'b0;
        cnt_wdata   = cnt_rd;
        o_idx_next  = 12'd0;
        o_cnt_next  = 32'd0;
        o_full_next = 1'b1;
        unique case (state_reg)
            ST_MIX0:
            begin
                mul_start = 1'b1;
                mul_a     = kb_reg;
                mul_b     = MIX_C1;
                x_next    = ka_reg;
            end
            ST_MIX1:
            begin
                if (mul_done)
                begin
                    x_next    = x_reg ^ mul_p;
                    mul_start = 1'b1;
                    mul_a     = {56'd0, chrom_reg};
                    mul_b     = MIX_C2;
                end
            end
            ST_MIX2:
            begin
                if (mul_done)
                begin
                    x_next    = (x_reg ^ mul_p) ^ ((x_reg ^ mul_p) >> 29);
                    mul_start = 1'b1;
                    mul_a     = (x_reg ^ mul_p) ^ ((x_reg ^ mul_p) >> 29);
                    mul_b     = MIX_C3;
                end
            end
            ST_MIX3:
            begin
                if (mul_done)
                begin
                    x_next = mul_p ^ (mul_p >> 32);
                end
            end
            ST_MIX4:
            begin
                slot_next  = x_reg[IDX_W-1:0];
                probe_next = '0;
            end
            ST_PROBE_CHK:
            begin
                if (!vld_rd)
                begin
                    key_we = 1'b1;
                end
                else if (!hit_cond)
                begin
                    slot_next  = (slot_reg == IDX_W'(TABLE_ENTRIES - 1)) ? '0
                               : slot_reg + IDX_W'(1);
                    probe_next = probe_reg + PRB_W'(1);
                end
            end
            ST_UPDATE:
            begin
                cnt_we = 1'b1;
                if (strand_reg)
                begin
                    cnt_wdata = {inc_cnt, vld_rd ? cnt_rd[31:0] : 32'd0};
                end
                else
                begin
                    cnt_wdata = {vld_rd ? cnt_rd[63:32] : 32'd0, inc_cnt};
                end
            end
            default:
            begin
            end
        endcase
    end

    // Table memories: one synchronous read, one write per cycle.
    // The valid bit is set with the count write, so vld_rd still marks a fresh insert.
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[slot_reg] <= {ka_reg, kb_reg, chrom_reg};
        end
        if (cnt_we)
        begin
            cnt_mem[slot_reg] <= cnt_wdata;
        end
        if (clr_busy_reg)
        begin
            vld_mem[clr_addr_reg] <= 1'b0;
        end
        else if (cnt_we)
        begin
            vld_mem[slot_reg] <= 1'b1;
        end
        if (state_reg == ST_PROBE_RD)
        begin
            key_rd <= key_mem[slot_reg];
            cnt_rd <= cnt_mem[slot_reg];
            vld_rd <= vld_mem[slot_reg];
        end
    end

    // Clearing pass over the valid memory after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + IDX_W'(1);
            if (clr_addr_reg == IDX_W'(TABLE_ENTRIES - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            min_len_reg   <= MIN_LEN_RESET;
            hist_reg      <= 2'd0;
            pstart_reg[0] <= '0;
            pstart_reg[1] <= '0;
            plen_reg[0]   <= '0;
            plen_reg[1]   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                min_len_reg <= cfg_wdata;
            end
            if (in_valid && in_ready)
            begin
                if (last_block)
                begin
                    hist_reg      <= 2'd0;
                    pstart_reg[0] <= '0;
                    pstart_reg[1] <= '0;
                    plen_reg[0]   <= '0;
                    plen_reg[1]   <= '0;
                end
                else
                begin
                    pstart_reg[0] <= pstart_reg[1];
                    plen_reg[0]   <= plen_reg[1];
                    pstart_reg[1] <= cur_start;
                    plen_reg[1]   <= block_length;
                    if (hist_reg != 2'd2)
                    begin
                        hist_reg <= hist_reg + 2'd1;
                    end
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Key capture, hash registers, working result and output register.
    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        slot_reg  <= slot_next;
        probe_reg <= probe_next;
        if (in_valid && in_ready)
        begin
            ka_reg     <= {pstart_reg[0] + 32'(plen_reg[0]), pstart_reg[1]};
            kb_reg     <= {pstart_reg[1] + 32'(plen_reg[1]), cur_start};
            chrom_reg  <= chrom_id;
            strand_reg <= strand;
        end
        if (state_reg == ST_PROBE_CHK)
        begin
            res_idx_reg  <= o_idx_next;
            res_cnt_reg  <= o_cnt_next;
            res_full_reg <= o_full_next;
        end
        if (state_reg == ST_UPDATE)
        begin
            res_idx_reg  <= 12'(slot_reg);
            res_cnt_reg  <= inc_cnt;
            res_full_reg <= 1'b0;
        end
        if (out_load)
        begin
            junction_start1 <= ka_reg[63:32];
            junction_end1   <= ka_reg[31:0];
            junction_start2 <= kb_reg[63:32];
            junction_end2   <= kb_reg[31:0];
            out_chrom       <= chrom_reg;
            out_strand      <= strand_reg;
            entry_index     <= res_idx_reg;
            new_count       <= res_cnt_reg;
            table_full      <= res_full_reg;
        end
    end

    `TJC_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_reg != ST_IDLE, !in_ready)
    `TJC_ASSERT_NEXT(a_out_after_done, clk, rst_n, out_load, out_valid)
    `TJC_ASSERT_IMP(a_hist_range, clk, rst_n, 1'b1, hist_reg != 2'd3)
    `TJC_ASSERT_IMP(a_no_accept_clear, clk, rst_n, clr_busy_reg, !in_ready)
endmodule
